// ===== sv/sofn_pkg.sv =====
package sofn_pkg;

    // fixed field widths
    localparam int ID_W      = 12;
    localparam int DIR_W     = 4;
    localparam int RAW_DIR_W = 5;
    localparam int ROW_W     = 16;
    localparam int OUT_COL_W = 12;
    localparam int LBL_W     = 24;
    localparam int CFG_W     = 16;
    localparam int COLREG_W  = 13;
    localparam int IDX_W     = 3;
    localparam int LB_W      = DIR_W + 2 * ID_W;

    localparam logic [LBL_W-1:0] LBL_MAX = '1;

    // input item kinds
    typedef enum logic [1:0] {
        OP_CELL  = 2'd0,
        OP_MARK  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_ROWS      = 3'd0,
        REG_COLS      = 3'd1,
        REG_LAST_ONLY = 3'd2,
        REG_NUM_SEQ   = 3'd3,
        REG_FILTER    = 3'd4
    } t_reg;

    // d8 direction codes
    localparam logic [DIR_W-1:0] DIR_NE = 4'd1;
    localparam logic [DIR_W-1:0] DIR_N  = 4'd2;
    localparam logic [DIR_W-1:0] DIR_NW = 4'd3;
    localparam logic [DIR_W-1:0] DIR_W_ = 4'd4;
    localparam logic [DIR_W-1:0] DIR_SW = 4'd5;
    localparam logic [DIR_W-1:0] DIR_S  = 4'd6;
    localparam logic [DIR_W-1:0] DIR_SE = 4'd7;
    localparam logic [DIR_W-1:0] DIR_E  = 4'd8;

    // one line buffer entry: cell one row up (with its direction) and two rows up
    typedef struct packed {
        logic [DIR_W-1:0] dir;
        logic [ID_W-1:0]  id_up;
        logic [ID_W-1:0]  id_up2;
    } t_lb_word;

    // one column of the 3x3 window
    typedef struct packed {
        logic [ID_W-1:0]  top;
        logic [ID_W-1:0]  mid;
        logic [ID_W-1:0]  bot;
        logic [DIR_W-1:0] dir;
    } t_column;

    // facts about the cell being decided
    typedef struct packed {
        logic have_k;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
        logic restart;
    } t_kflags;

    // absolute d8 code, zero when out of range
    function automatic logic [DIR_W-1:0] dir_magnitude(input logic [RAW_DIR_W-1:0] raw);
        logic [RAW_DIR_W-1:0] mag;
        mag = raw[RAW_DIR_W-1] ? (RAW_DIR_W'(0) - raw) : raw;
        return (mag > RAW_DIR_W'(8)) ? '0 : mag[DIR_W-1:0];
    endfunction

endpackage

// ===== sv/sofn_ram.sv =====
module sofn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port, read returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sofn_front.sv =====
module sofn_front import sofn_pkg::*; #(
    parameter int LINE_COLS = 4096,
    localparam int CW = $clog2(LINE_COLS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_restart,
    input  t_op              i_op,
    input  logic [ROW_W-1:0] i_rows,
    input  logic [ROW_W-1:0] i_last_row,
    input  logic [CW:0]      i_cols,
    input  logic [CW-1:0]    i_last_col,
    output logic             o_pos,
    output logic [CW-1:0]    o_col,
    output t_kflags          o_flags,
    output logic [ROW_W-1:0] o_kr,
    output logic [CW-1:0]    o_kc
);

    logic [ROW_W:0] r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic           in_frame;
    logic           col_nz;
    logic           wrap;
    logic [ROW_W:0] kr_full;

    // raster position of the arriving item, flush ticks continue past the last row
    assign in_frame = r_row < {1'b0, i_rows};
    assign col_nz   = (r_col != '0);
    assign o_pos    = ((i_op == OP_CELL) && in_frame) || ((i_op == OP_FLUSH) && !in_frame);
    assign o_col    = r_col;
    assign wrap     = (({1'b0, r_col} + (CW+1)'(1)) == i_cols);

    // decided cell sits one row and one column back
    assign kr_full = col_nz ? (r_row - (ROW_W+1)'(1)) : (r_row - (ROW_W+1)'(2));
    assign o_kr    = kr_full[ROW_W-1:0];
    assign o_kc    = col_nz ? (r_col - CW'(1)) : i_last_col;

    // bounds of the decided cell
    assign o_flags.have_k   = (r_row[ROW_W:1] != '0) || (r_row[0] && col_nz);
    assign o_flags.top_ok   = (o_kr != '0);
    assign o_flags.bot_ok   = (o_kr != i_last_row);
    assign o_flags.left_ok  = (o_kc != '0);
    assign o_flags.right_ok = (o_kc != i_last_col);
    assign o_flags.last     = !o_flags.bot_ok && !o_flags.right_ok;
    assign o_flags.restart  = (i_op == OP_FLUSH) && o_flags.have_k && o_flags.last;

    // position advance
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (i_accept && o_pos) begin
            if (o_flags.restart) begin
                n_row = '0;
                n_col = '0;
            end else if (wrap) begin
                n_row = r_row + (ROW_W+1)'(1);
                n_col = '0;
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

// ===== sv/sofn_window.sv =====
module sofn_window import sofn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_shift,
    input  t_column         i_col,
    input  logic            i_pos,
    input  t_kflags         i_flags,
    input  logic            i_last_only,
    output logic            o_emit,
    output logic [ID_W-1:0] o_cur
);

    t_column         r_prev;
    logic [ID_W-1:0] r_back_top, r_back_mid, r_back_bot;
    logic [ID_W-1:0] nb_val;
    logic            nb_ok;
    logic [ID_W-1:0] next_id;

    // window columns: back (c-1), prev (c, holds the decided cell), i_col (c+1)
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_prev     <= i_col;
            r_back_top <= r_prev.top;
            r_back_mid <= r_prev.mid;
            r_back_bot <= r_prev.bot;
        end
    end

    assign o_cur = r_prev.mid;

    // downstream neighbor select
    always_comb begin
        nb_val = '0;
        nb_ok  = 1'b0;
        case (r_prev.dir)
            DIR_NE: begin
                nb_val = i_col.top;
                nb_ok  = i_flags.top_ok && i_flags.right_ok;
            end
            DIR_N: begin
                nb_val = r_prev.top;
                nb_ok  = i_flags.top_ok;
            end
            DIR_NW: begin
                nb_val = r_back_top;
                nb_ok  = i_flags.top_ok && i_flags.left_ok;
            end
            DIR_W_: begin
                nb_val = r_back_mid;
                nb_ok  = i_flags.left_ok;
            end
            DIR_SW: begin
                nb_val = r_back_bot;
                nb_ok  = i_flags.bot_ok && i_flags.left_ok;
            end
            DIR_S: begin
                nb_val = r_prev.bot;
                nb_ok  = i_flags.bot_ok;
            end
            DIR_SE: begin
                nb_val = i_col.bot;
                nb_ok  = i_flags.bot_ok && i_flags.right_ok;
            end
            DIR_E: begin
                nb_val = i_col.mid;
                nb_ok  = i_flags.right_ok;
            end
            default: begin
                nb_val = '0;
                nb_ok  = 1'b0;
            end
        endcase
    end

    assign next_id = nb_ok ? nb_val : '0;

    // outlet or junction test, before the category filter
    assign o_emit = i_pos && i_flags.have_k && (o_cur != '0)
                    && (i_last_only ? (next_id == '0) : (o_cur != next_id));

endmodule

// ===== sv/stream_outlet_node_finder.sv =====
// channel     | dir | handshake                         | payload
// s_axis      | in  | i_s_axis_tvalid / o_s_axis_tready | tdata: stream_value, direction; tuser: op
// m_axis      | out | o_m_axis_tvalid / i_m_axis_tready | tdata: out_row, out_col, label; tlast
// cfg         | in  | i_cfg_we (no wait)                | i_cfg_index, i_cfg_data
//
// one item per clock sustained while the output is taken and no clearing pass runs; a result
// passes stage 1 and stage 2 into the output register; the line buffer read (one access per item) sets that pace
// after reset a pass clears the category memory, one entry per clock (MAX_STREAMS+1
// entries, at most 4096) with the input not ready; config writes are taken meanwhile
// a stalled output backs up through two holding stages before the input stops
module stream_outlet_node_finder import sofn_pkg::*; #(
    parameter int LINE_COLS   = 4096,
    parameter int MAX_STREAMS = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [23:0]          i_s_axis_tdata,   // stream_value[11:0], direction[16:12]
    input  logic [1:0]           i_s_axis_tuser,   // op[1:0]
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [55:0]          o_m_axis_tdata,   // out_row[15:0], out_col[27:16], label[51:28]
    output logic                 o_m_axis_tlast    // frame_end
);

    localparam int CW         = $clog2(LINE_COLS);
    localparam int MARK_DEPTH = (MAX_STREAMS + 1 < 4096) ? (MAX_STREAMS + 1) : 4096;
    localparam int MA         = $clog2(MARK_DEPTH);
    localparam logic [16:0] MAXS = 17'(MAX_STREAMS);

    // configuration registers
    logic [ROW_W-1:0] r_rows, r_last_row;
    logic [CW:0]      r_cols;
    logic [CW-1:0]    r_last_col;
    logic             r_last_only, r_num_seq, r_filt_en;
    logic [ROW_W-1:0] rows_new, last_row_new;
    logic [CW:0]      cols_new, last_col_full;
    logic [CW+COLREG_W:0] cols_ext;
    logic             cfg_restart;

    // category clearing pass
    logic             r_clr_busy;
    logic [MA-1:0]    r_clr_addr;

    // handshake and stage control
    logic             out_take, s2_free, s1_free, s1_move, s2_move, accept;

    // input fields
    t_op              in_op;
    logic [ID_W-1:0]  in_value;
    logic [DIR_W-1:0] in_dir;
    logic             in_mark_ok;

    // front outputs
    logic             front_pos;
    logic [CW-1:0]    front_col;
    t_kflags          front_flags;
    logic [ROW_W-1:0] front_kr;
    logic [CW-1:0]    front_kc;

    // stage 1
    logic             r_s1_valid;
    logic             r_s1_pos, r_s1_mark, r_s1_fwd;
    logic [ID_W-1:0]  r_s1_value;
    logic [DIR_W-1:0] r_s1_dir;
    t_kflags          r_s1_flags;
    logic [ROW_W-1:0] r_s1_kr;
    logic [CW-1:0]    r_s1_kc;
    logic [CW-1:0]    r_s1_addr;
    t_lb_word         r_s1_fwd_data;
    logic [LB_W-1:0]  lb_rdata;
    t_lb_word         col_word;
    t_lb_word         lb_wdata;
    t_column          cur_col;
    logic             win_emit;
    logic [ID_W-1:0]  win_cur;

    // stage 2
    logic             r_s2_valid;
    logic             r_s2_emit, r_s2_cur_hi, r_s2_last, r_s2_restart;
    logic [ID_W-1:0]  r_s2_cur;
    logic [ROW_W-1:0] r_s2_kr;
    logic [CW-1:0]    r_s2_kc;
    logic             mark_q;
    logic             mark_we, mark_wdata;
    logic [MA-1:0]    mark_waddr;
    logic             emit_final;
    logic [LBL_W-1:0] r_emit_cnt;
    logic [LBL_W-1:0] label_new;
    logic [CW+OUT_COL_W-1:0] col_ext;

    // output register
    logic                 r_o_valid;
    logic [ROW_W-1:0]     r_o_row;
    logic [OUT_COL_W-1:0] r_o_col;
    logic [LBL_W-1:0]     r_o_label;
    logic                 r_o_last;

    // effective frame size from a config write
    always_comb begin
        rows_new = (i_cfg_data == '0) ? ROW_W'(1) : i_cfg_data;
        last_row_new = rows_new - ROW_W'(1);
        cols_ext = {{(CW+1){1'b0}}, i_cfg_data[COLREG_W-1:0]};
        if (i_cfg_data[COLREG_W-1:0] == '0) begin
            cols_new = (CW+1)'(1);
        end else if (32'(i_cfg_data[COLREG_W-1:0]) > 32'(LINE_COLS)) begin
            cols_new = (CW+1)'(LINE_COLS);
        end else begin
            cols_new = cols_ext[CW:0];
        end
        last_col_full = cols_new - (CW+1)'(1);
    end

    assign cfg_restart = i_cfg_we
                         && ((i_cfg_index == REG_ROWS) || (i_cfg_index == REG_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows      <= ROW_W'(1);
            r_last_row  <= '0;
            r_cols      <= (CW+1)'(1);
            r_last_col  <= '0;
            r_last_only <= 1'b0;
            r_num_seq   <= 1'b0;
            r_filt_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROWS: begin
                    r_rows     <= rows_new;
                    r_last_row <= last_row_new;
                end
                REG_COLS: begin
                    r_cols     <= cols_new;
                    r_last_col <= last_col_full[CW-1:0];
                end
                REG_LAST_ONLY: r_last_only <= i_cfg_data[0];
                REG_NUM_SEQ:   r_num_seq   <= i_cfg_data[0];
                REG_FILTER:    r_filt_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow
    assign out_take        = !r_o_valid || i_m_axis_tready;
    assign s2_free         = !r_s2_valid || out_take;
    assign s1_free         = !r_s1_valid || s2_free;
    assign s1_move         = r_s1_valid && s2_free;
    assign s2_move         = r_s2_valid && out_take;
    assign o_s_axis_tready = s1_free && !r_clr_busy;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // input unpacking
    assign in_op      = t_op'(i_s_axis_tuser);
    assign in_value   = i_s_axis_tdata[ID_W-1:0];
    assign in_dir     = dir_magnitude(i_s_axis_tdata[ID_W+RAW_DIR_W-1:ID_W]);
    assign in_mark_ok = (in_op == OP_MARK) && (in_value != '0) && ({5'd0, in_value} <= MAXS);

    sofn_front #(
        .LINE_COLS (LINE_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_restart  (cfg_restart),
        .i_op       (in_op),
        .i_rows     (r_rows),
        .i_last_row (r_last_row),
        .i_cols     (r_cols),
        .i_last_col (r_last_col),
        .o_pos      (front_pos),
        .o_col      (front_col),
        .o_flags    (front_flags),
        .o_kr       (front_kr),
        .o_kc       (front_kc)
    );

    // line buffer: read at accept, write back when the item leaves stage 1
    assign lb_wdata.dir    = r_s1_dir;
    assign lb_wdata.id_up  = r_s1_value;
    assign lb_wdata.id_up2 = col_word.id_up;

    sofn_ram #(
        .WIDTH (LB_W),
        .DEPTH (LINE_COLS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move && r_s1_pos),
        .i_waddr (r_s1_addr),
        .i_wdata (lb_wdata),
        .i_re    (accept),
        .i_raddr (front_col),
        .o_rdata (lb_rdata)
    );

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= accept;
        end
    end

    // stage 1 payload, forward the write of the leaving item on a same column read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos      <= front_pos;
            r_s1_mark     <= in_mark_ok;
            r_s1_value    <= (in_op == OP_FLUSH) ? '0 : in_value;
            r_s1_dir      <= (in_op == OP_CELL) ? in_dir : '0;
            r_s1_flags    <= front_flags;
            r_s1_kr       <= front_kr;
            r_s1_kc       <= front_kc;
            r_s1_addr     <= front_col;
            r_s1_fwd      <= r_s1_valid && r_s1_pos && front_pos && (r_s1_addr == front_col);
            r_s1_fwd_data <= lb_wdata;
        end
    end

    assign col_word    = r_s1_fwd ? r_s1_fwd_data : t_lb_word'(lb_rdata);
    assign cur_col.top = col_word.id_up2;
    assign cur_col.mid = col_word.id_up;
    assign cur_col.dir = col_word.dir;
    assign cur_col.bot = r_s1_value;

    sofn_window u_window (
        .i_clk       (i_clk),
        .i_shift     (s1_move && r_s1_pos),
        .i_col       (cur_col),
        .i_pos       (r_s1_pos),
        .i_flags     (r_s1_flags),
        .i_last_only (r_last_only),
        .o_emit      (win_emit),
        .o_cur       (win_cur)
    );

    // category marks: clearing pass, then marks from items, lookup of the decided id
    assign mark_we    = r_clr_busy || (s1_move && r_s1_mark);
    assign mark_waddr = r_clr_busy ? r_clr_addr : r_s1_value[MA-1:0];
    assign mark_wdata = !r_clr_busy;

    sofn_ram #(
        .WIDTH (1),
        .DEPTH (MARK_DEPTH)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (s1_move),
        .i_raddr (win_cur[MA-1:0]),
        .o_rdata (mark_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + MA'(1);
            if (r_clr_addr == MA'(MARK_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_emit    <= win_emit;
            r_s2_cur     <= win_cur;
            r_s2_cur_hi  <= {5'd0, win_cur} > MAXS;
            r_s2_kr      <= r_s1_kr;
            r_s2_kc      <= r_s1_kc;
            r_s2_last    <= r_s1_flags.last;
            r_s2_restart <= r_s1_pos && r_s1_flags.restart;
        end
    end

    // filter and label
    assign emit_final = r_s2_emit && (!r_filt_en || (!r_s2_cur_hi && mark_q));
    assign label_new  = r_num_seq ? ((r_emit_cnt == LBL_MAX) ? LBL_MAX
                                                              : r_emit_cnt + LBL_W'(1))
                                  : {{(LBL_W-ID_W){1'b0}}, r_s2_cur};
    assign col_ext    = {{OUT_COL_W{1'b0}}, r_s2_kc};

    // emission counter, cleared at frame end and on a size write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_cnt <= '0;
        end else if (cfg_restart) begin
            r_emit_cnt <= '0;
        end else if (s2_move) begin
            if (r_s2_restart) begin
                r_emit_cnt <= '0;
            end else if (emit_final && (r_emit_cnt != LBL_MAX)) begin
                r_emit_cnt <= r_emit_cnt + LBL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_take) begin
            r_o_valid <= r_s2_valid && emit_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move && emit_final) begin
            r_o_row   <= r_s2_kr;
            r_o_col   <= col_ext[OUT_COL_W-1:0];
            r_o_label <= label_new;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {4'd0, r_o_label, r_o_col, r_o_row};
    assign o_m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    // column position never reaches the column count
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, front_col} < r_cols)
        else $error("column position out of range");

    // a full pipeline with a stalled output takes no item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && r_o_valid && !i_m_axis_tready) |-> !accept)
        else $error("item taken into a full pipeline");

    // frame end clears the emission count
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_move && r_s2_restart) |=> (r_emit_cnt == '0))
        else $error("emission count kept past frame end");

    // forwarding only for a cell that uses the line buffer
    a_fwd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_fwd) |-> r_s1_pos)
        else $error("forward on a non-raster item");
`endif

endmodule
